@@ rtl/bbc_pkg.sv @@
// Shared types, constants and helper functions of the bracket balance checker.
package bbc_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int LINE_BITS   = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // request commands
   localparam logic CMD_CHAR   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // result status codes
   localparam logic [2:0] ST_BALANCED  = 3'd0;
   localparam logic [2:0] ST_EXTRA     = 3'd1;
   localparam logic [2:0] ST_MISMATCH  = 3'd2;
   localparam logic [2:0] ST_UNMATCHED = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;
   localparam logic [2:0] ST_ERRORS    = 3'd5;

   // operations passed from front to back
   localparam logic [1:0] OP_OPEN   = 2'd0;
   localparam logic [1:0] OP_CLOSE  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // bracket kinds
   localparam logic [1:0] KIND_PAREN = 2'd0;
   localparam logic [1:0] KIND_BRACK = 2'd1;
   localparam logic [1:0] KIND_BRACE = 2'd2;

   // character bytes
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;

   typedef struct packed {
      logic        command;
      logic [7:0]  ch;
      logic [15:0] line_no;
      logic        first_of_line;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] err_line;
      logic [7:0]  open_char;
      logic [7:0]  close_char;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [1:0]           kind;
      logic [LINE_BITS-1:0] line;
   } op_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [LINE_BITS-1:0] line;
   } entry_type;

   function automatic logic [7:0] open_byte(input logic [1:0] kind);
      logic [7:0] b;
      case (kind)
         KIND_PAREN: b = CH_LPAREN;
         KIND_BRACK: b = CH_LBRACK;
         default:    b = CH_LBRACE;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] close_byte(input logic [1:0] kind);
      logic [7:0] b;
      case (kind)
         KIND_PAREN: b = CH_RPAREN;
         KIND_BRACK: b = CH_RBRACK;
         default:    b = CH_RBRACE;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/bracket_balance_checker.sv @@
// Top level of the bracket balance checker: front end, op queue and stack back end.
//
// Checks bracket balance over a stream of source characters. Each request is one
// character (with its line number and a first-of-line mark) or a finish command.
// The front end accepts one request per clock whenever its 4-entry op queue has
// room, tracks string mode (double quotes toggle it, a new line clears it) and
// forwards only brackets outside strings plus finish. The back end executes ops
// against a 32-deep stack RAM: an opener, an overflow report or an extra-closer
// report is handled in the idle state alone; a closer that pops the stack also
// passes S_POP (registered stack read, then the kind compare), and finish passes
// S_FLUSH and S_FLUSH_RD per unmatched opener, then S_FLUSH for the summary.
// Results leave through one output register: extra closer, mismatch and overflow
// reports as they happen, and on finish each unmatched opener from the top down
// followed by a summary result (balanced or errors) with last set; finish also
// clears all state.
module bracket_balance_checker import bbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   // result channel
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic   q_wr_en, q_full, q_rd_en, q_empty;
   op_type q_wr_data, q_rd_data;

   // classify requests, keep string mode
   bbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .q_full    (q_full),
      .full      (full),
      .q_wr_en   (q_wr_en),
      .q_wr_data (q_wr_data)
   );

   // decouples the front, one op per cycle while the queue has room, from the slower back
   bbc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_rd_en),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   // stack execution, flush sequencing, result register
   bbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_rd_data (q_rd_data),
      .q_rd_en   (q_rd_en),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/bbc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bbc_front.sv @@
// Front end: accepts requests, tracks string mode and classifies brackets.
module bbc_front import bbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_data,
   input  logic    q_full,
   output logic    full,
   output logic    q_wr_en,
   output op_type  q_wr_data
);

   logic in_quotes_ff, in_quotes_in;
   logic accept, quotes_now, op_valid;
   logic is_open, is_close;
   logic [1:0] kind;

   assign full   = q_full;
   assign accept = push && !q_full;

   // new line drops string mode before the character is looked at
   assign quotes_now = req_data.first_of_line ? 1'b0 : in_quotes_ff;

   always_comb begin
      is_open  = 1'b0;
      is_close = 1'b0;
      kind     = KIND_PAREN;
      unique case (req_data.ch)
         CH_LPAREN: begin is_open  = 1'b1; kind = KIND_PAREN; end
         CH_LBRACK: begin is_open  = 1'b1; kind = KIND_BRACK; end
         CH_LBRACE: begin is_open  = 1'b1; kind = KIND_BRACE; end
         CH_RPAREN: begin is_close = 1'b1; kind = KIND_PAREN; end
         CH_RBRACK: begin is_close = 1'b1; kind = KIND_BRACK; end
         CH_RBRACE: begin is_close = 1'b1; kind = KIND_BRACE; end
         default: ;
      endcase
   end

   always_comb begin
      op_valid         = 1'b0;
      q_wr_data.op     = OP_OPEN;
      q_wr_data.kind   = kind;
      q_wr_data.line   = LINE_BITS'(req_data.line_no);
      in_quotes_in     = in_quotes_ff;
      if (req_data.command == CMD_FINISH) begin
         op_valid     = 1'b1;
         q_wr_data.op = OP_FINISH;
         in_quotes_in = 1'b0;
      end else if (req_data.ch == CH_QUOTE) begin
         in_quotes_in = !quotes_now;
      end else begin
         in_quotes_in = quotes_now;
         if (!quotes_now && (is_open || is_close)) begin
            op_valid     = 1'b1;
            q_wr_data.op = is_open ? OP_OPEN : OP_CLOSE;
         end
      end
   end

   assign q_wr_en = accept && op_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff <= 1'b0;
      end else if (accept) begin
         in_quotes_ff <= in_quotes_in;
      end
   end

endmodule

@@ rtl/bbc_queue.sv @@
// Short FIFO of classified operations between front and back.
module bbc_queue import bbc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   wr_en,
   input  op_type wr_data,
   output logic   full,
   input  logic   rd_en,
   output op_type rd_data,
   output logic   empty
);

   op_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full    = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_wr) begin
         tail_in = (tail_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_rd) begin
         head_in = (head_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[tail_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/bbc_back.sv @@
// Back end: runs the bracket stack, flushes on finish and holds the result register.
module bbc_back import bbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  op_type  q_rd_data,
   output logic    q_rd_en,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_POP      = 2'd1;
   localparam logic [1:0] S_FLUSH    = 2'd2;
   localparam logic [1:0] S_FLUSH_RD = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in, count_dec;
   logic                error_ff, error_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, emit_data;
   logic [1:0]          cur_kind_ff, cur_kind_in;
   logic [LINE_BITS-1:0] cur_line_ff, cur_line_in;
   logic                emit, out_space;
   logic                wr_en, rd_en;
   entry_type           wr_entry, rd_entry;
   logic [ADDR_BITS-1:0] rd_addr;

   assign out_space = !rsp_valid_ff || pop;
   assign count_dec = count_ff - CNT_BITS'(1);
   assign rd_addr   = count_dec[ADDR_BITS-1:0];
   assign wr_entry  = '{kind: q_rd_data.kind, line: q_rd_data.line};

   bbc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      error_in    = error_ff;
      cur_kind_in = cur_kind_ff;
      cur_line_in = cur_line_ff;
      q_rd_en     = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      emit        = 1'b0;
      emit_data   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               unique case (q_rd_data.op)
                  OP_OPEN: begin
                     if (count_ff < CNT_BITS'(STACK_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_BITS'(1);
                        q_rd_en  = 1'b1;
                     end else if (out_space) begin
                        emit                = 1'b1;
                        emit_data.status    = ST_OVERFLOW;
                        emit_data.err_line  = 16'(q_rd_data.line);
                        emit_data.open_char = open_byte(q_rd_data.kind);
                        error_in            = 1'b1;
                        q_rd_en             = 1'b1;
                     end
                  end
                  OP_CLOSE: begin
                     if (count_ff != '0) begin
                        rd_en       = 1'b1;
                        count_in    = count_dec;
                        cur_kind_in = q_rd_data.kind;
                        cur_line_in = q_rd_data.line;
                        q_rd_en     = 1'b1;
                        state_in    = S_POP;
                     end else if (out_space) begin
                        emit                 = 1'b1;
                        emit_data.status     = ST_EXTRA;
                        emit_data.err_line   = 16'(q_rd_data.line);
                        emit_data.close_char = close_byte(q_rd_data.kind);
                        error_in             = 1'b1;
                        q_rd_en              = 1'b1;
                     end
                  end
                  OP_FINISH: begin
                     q_rd_en  = 1'b1;
                     state_in = S_FLUSH;
                  end
                  default: begin
                     q_rd_en = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            // popped opener arrives from the stack RAM this cycle
            if (rd_entry.kind == cur_kind_ff) begin
               state_in = S_IDLE;
            end else if (out_space) begin
               emit                 = 1'b1;
               emit_data.status     = ST_MISMATCH;
               emit_data.err_line   = 16'(cur_line_ff);
               emit_data.open_char  = open_byte(rd_entry.kind);
               emit_data.close_char = close_byte(cur_kind_ff);
               error_in             = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (count_ff != '0) begin
               rd_en    = 1'b1;
               count_in = count_dec;
               state_in = S_FLUSH_RD;
            end else if (out_space) begin
               emit             = 1'b1;
               emit_data.status = error_ff ? ST_ERRORS : ST_BALANCED;
               emit_data.last   = 1'b1;
               error_in         = 1'b0;
               state_in         = S_IDLE;
            end
         end
         S_FLUSH_RD: begin
            if (out_space) begin
               emit                = 1'b1;
               emit_data.status    = ST_UNMATCHED;
               emit_data.err_line  = 16'(rd_entry.line);
               emit_data.open_char = open_byte(rd_entry.kind);
               error_in            = 1'b1;
               state_in            = S_FLUSH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_kind_ff <= cur_kind_in;
      cur_line_ff <= cur_line_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_flush_rd_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH_RD) |-> ($past(rd_en) || $past(state_ff == S_FLUSH_RD)))
      else $error("flush report without a stack read");

   a_summary_empty_stack: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_data.last) |=> (count_ff == '0 && !error_ff))
      else $error("summary left state behind");

   a_no_emit_on_full_output: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_space)
      else $error("result written over an untaken result");

endmodule
